FILE: sv/decimal_float_amount_codec_defines.svh
// Assertion macros shared by the decimal float amount codec RTL.
`ifndef DECIMAL_FLOAT_AMOUNT_CODEC_DEFINES_SVH
`define DECIMAL_FLOAT_AMOUNT_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF
`define DFAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DFAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFAC_ASSERT_IMP(lbl, ante, cons, msg)
`define DFAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/dfac_pkg.sv
// Types and constants shared by the decimal float amount codec.
package dfac_pkg;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [63:0] STRIP_MIN = 64'd32;
  localparam logic [63:0] SIG_LIMIT = 64'd1000000000000;
  // Largest value that can still be multiplied by ten without overflow.
  localparam logic [63:0] MUL_LIMIT = 64'd1844674407370955161;
  localparam logic [4:0]  MAX_ZEROS = 5'd19;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_NO_FIT = 2'd1;
  localparam status_t ST_LEN    = 2'd2;
  localparam status_t ST_OVF    = 2'd3;

  localparam logic [2:0] HDR_F0 = 3'b000;
  localparam logic [2:0] HDR_F1 = 3'b001;
  localparam logic [2:0] HDR_F2 = 3'b010;
  localparam logic [2:0] HDR_F3 = 3'b011;
  localparam logic [2:0] HDR_F4 = 3'b100;
  localparam logic [2:0] HDR_F5 = 3'b101;
  localparam logic [1:0] HDR_F6 = 2'b11;

  localparam logic [2:0] LEN_F0 = 3'd1;
  localparam logic [2:0] LEN_F1 = 3'd2;
  localparam logic [2:0] LEN_F2 = 3'd3;
  localparam logic [2:0] LEN_F3 = 3'd4;
  localparam logic [2:0] LEN_F4 = 3'd5;
  localparam logic [2:0] LEN_F5 = 3'd6;
  localparam logic [2:0] LEN_F6 = 3'd7;

  typedef struct packed {
    logic [55:0] coded;
    logic [2:0]  len;
    status_t     status;
  } pack_res_t;

  typedef struct packed {
    logic [53:0] mant;
    logic [3:0]  ex;
    logic        len_ok;
  } unpack_res_t;

endpackage

FILE: sv/dfac_alu.sv
// Shared 64-bit adder and divisible-by-ten test of the codec sequencer.
module dfac_alu (
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  input  logic [63:0] tst,
  output logic [63:0] sum,
  output logic        div10
);
  logic [4:0] pair [8];
  logic [7:0] tot;
  logic [4:0] fold1;
  logic [3:0] fold2;

  assign sum = opa + opb;

  // Sixteen is one modulo five, so the nibble sum keeps the residue.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pair[i] = {1'b0, tst[8*i +: 4]} + {1'b0, tst[8*i+4 +: 4]};
    end
    tot = 8'd0;
    for (int i = 0; i < 8; i++) begin
      tot = tot + {3'b000, pair[i]};
    end
    fold1 = {1'b0, tot[7:4]} + {1'b0, tot[3:0]};
    fold2 = {3'b000, fold1[4]} + fold1[3:0];
  end

  assign div10 = !tst[0] &&
                 (fold2 == 4'd0 || fold2 == 4'd5 || fold2 == 4'd10 || fold2 == 4'd15);

endmodule

FILE: sv/dfac_pack.sv
// Mantissa selection, format choice and code packing for the encoder.
module dfac_pack (
  input  logic [63:0]           sig,
  input  logic [63:0]           amt,
  input  logic [4:0]            zeros_in,
  output dfac_pkg::pack_res_t   res
);
  import dfac_pkg::*;

  logic        use_sig;
  logic [63:0] mant;
  logic [4:0]  zeros;

  always_comb begin
    use_sig = sig < SIG_LIMIT;
    mant    = use_sig ? sig : amt;
    zeros   = use_sig ? zeros_in : 5'd0;
    res.status = ST_OK;
    res.coded  = 56'd0;
    res.len    = 3'd0;
    if (mant[63:5] == 59'd0 && zeros == 5'd0) begin
      res.coded = {HDR_F0, mant[4:0], 48'd0};
      res.len   = LEN_F0;
    end else if (mant[63:9] == 55'd0 && !zeros[4]) begin
      res.coded = {HDR_F1, mant[8:0], zeros[3:0], 40'd0};
      res.len   = LEN_F1;
    end else if (mant[63:17] == 47'd0 && !zeros[4]) begin
      res.coded = {HDR_F2, mant[16:0], zeros[3:0], 32'd0};
      res.len   = LEN_F2;
    end else if (mant[63:25] == 39'd0 && !zeros[4]) begin
      res.coded = {HDR_F3, mant[24:0], zeros[3:0], 24'd0};
      res.len   = LEN_F3;
    end else if (mant[63:34] == 30'd0 && zeros[4:3] == 2'd0) begin
      res.coded = {HDR_F4, mant[33:0], zeros[2:0], 16'd0};
      res.len   = LEN_F4;
    end else if (mant[63:42] == 22'd0 && zeros[4:3] == 2'd0) begin
      res.coded = {HDR_F5, mant[41:0], zeros[2:0], 8'd0};
      res.len   = LEN_F5;
    end else if (mant[63:54] == 10'd0 && zeros == 5'd0) begin
      res.coded = {HDR_F6, mant[53:0]};
      res.len   = LEN_F6;
    end else begin
      res.status = ST_NO_FIT;
    end
  end

endmodule

FILE: sv/dfac_unpack.sv
// Header decode and field extraction for the decoder.
module dfac_unpack (
  input  logic [55:0]            coded,
  input  logic [2:0]             nbytes,
  output dfac_pkg::unpack_res_t  res
);
  import dfac_pkg::*;

  logic [2:0] len;

  always_comb begin
    res.mant = 54'd0;
    res.ex   = 4'd0;
    case (coded[55:53])
      HDR_F0: begin
        res.mant = {49'd0, coded[52:48]};
        len      = LEN_F0;
      end
      HDR_F1: begin
        res.mant = {45'd0, coded[52:44]};
        res.ex   = coded[43:40];
        len      = LEN_F1;
      end
      HDR_F2: begin
        res.mant = {37'd0, coded[52:36]};
        res.ex   = coded[35:32];
        len      = LEN_F2;
      end
      HDR_F3: begin
        res.mant = {29'd0, coded[52:28]};
        res.ex   = coded[27:24];
        len      = LEN_F3;
      end
      HDR_F4: begin
        res.mant = {20'd0, coded[52:19]};
        res.ex   = {1'b0, coded[18:16]};
        len      = LEN_F4;
      end
      HDR_F5: begin
        res.mant = {12'd0, coded[52:11]};
        res.ex   = {1'b0, coded[10:8]};
        len      = LEN_F5;
      end
      default: begin
        // Two-bit header: the whole rest of the code is mantissa.
        res.mant = coded[53:0];
        len      = LEN_F6;
      end
    endcase
    res.len_ok = nbytes == len;
  end

endmodule

FILE: sv/decimal_float_amount_codec.sv
// Top level of the decimal float amount codec: sequencer around one shared adder.
// Encode: amounts below 32 go straight to packing; larger ones first strip the trailing
// decimal zeros (at most 19), each costing a test and six adder passes. Decode: one adder
// pass per factor of ten (exponent at most 15); a length mismatch is flagged from idle
// without raising busy, and overflow stops early. Else busy stays high until the strobe.
// Results last one cycle each and cannot be stalled. Synchronous reset returns to idle.
module decimal_float_amount_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_amount_in,
  input  logic [55:0] in_coded_in,
  input  logic [2:0]  in_coded_bytes_in,
  output logic        out_valid,
  output logic [63:0] out_amount_out,
  output logic [55:0] out_coded_out,
  output logic [2:0]  out_coded_len,
  output dfac_pkg::status_t out_status
);
  import dfac_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TEST, S_DIV, S_PACK, S_MUL} state_t;

  localparam logic [2:0] DIV_LAST = 3'd5;

  state_t      state_r, state_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] amt_r, amt_nxt;
  logic [4:0]  z_r, z_nxt;
  logic [3:0]  ex_r, ex_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [63:0] oamt_r, oamt_nxt;
  logic [55:0] ocode_r, ocode_nxt;
  logic [2:0]  olen_r, olen_nxt;
  status_t     ostat_r, ostat_nxt;

  logic [63:0] opa, opb, sum;
  logic        div10;
  pack_res_t   pk;
  unpack_res_t up;

  dfac_alu u_alu (
    .opa   (opa),
    .opb   (opb),
    .tst   (v_r),
    .sum   (sum),
    .div10 (div10)
  );

  dfac_pack u_pack (
    .sig      (v_r),
    .amt      (amt_r),
    .zeros_in (z_r),
    .res      (pk)
  );

  dfac_unpack u_unpack (
    .coded  (in_coded_in),
    .nbytes (in_coded_bytes_in),
    .res    (up)
  );

  // Exact division of x = v/2 by five: x times the inverse of five modulo 2^64,
  // built as x + 4 * (3x * 0x1111...1) over six adder passes.
  always_comb begin
    opa = {v_r[60:0], 3'b000};
    opb = {v_r[62:0], 1'b0};
    if (state_r == S_DIV) begin
      case (step_r)
        3'd0: begin
          opa = x_r;
          opb = {x_r[62:0], 1'b0};
        end
        3'd1: begin
          opa = acc_r;
          opb = {acc_r[59:0], 4'd0};
        end
        3'd2: begin
          opa = acc_r;
          opb = {acc_r[55:0], 8'd0};
        end
        3'd3: begin
          opa = acc_r;
          opb = {acc_r[47:0], 16'd0};
        end
        3'd4: begin
          opa = acc_r;
          opb = {acc_r[31:0], 32'd0};
        end
        default: begin
          opa = x_r;
          opb = {acc_r[61:0], 2'b00};
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    amt_nxt   = amt_r;
    z_nxt     = z_r;
    ex_nxt    = ex_r;
    step_nxt  = step_r;
    valid_nxt = 1'b0;
    oamt_nxt  = oamt_r;
    ocode_nxt = ocode_r;
    olen_nxt  = olen_r;
    ostat_nxt = ostat_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_ENC) begin
            amt_nxt   = in_amount_in;
            v_nxt     = in_amount_in;
            z_nxt     = 5'd0;
            state_nxt = (in_amount_in >= STRIP_MIN) ? S_TEST : S_PACK;
          end else if (!up.len_ok) begin
            valid_nxt = 1'b1;
            oamt_nxt  = 64'd0;
            ocode_nxt = 56'd0;
            olen_nxt  = 3'd0;
            ostat_nxt = ST_LEN;
          end else begin
            v_nxt     = {10'd0, up.mant};
            ex_nxt    = up.ex;
            state_nxt = S_MUL;
          end
        end
      end
      S_TEST: begin
        if (div10) begin
          x_nxt     = {1'b0, v_r[63:1]};
          step_nxt  = 3'd0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_PACK;
        end
      end
      S_DIV: begin
        acc_nxt  = sum;
        step_nxt = step_r + 3'd1;
        if (step_r == DIV_LAST) begin
          v_nxt     = sum;
          z_nxt     = z_r + 5'd1;
          state_nxt = S_TEST;
        end
      end
      S_PACK: begin
        valid_nxt = 1'b1;
        oamt_nxt  = 64'd0;
        ocode_nxt = pk.coded;
        olen_nxt  = pk.len;
        ostat_nxt = pk.status;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        if (ex_r == 4'd0) begin
          valid_nxt = 1'b1;
          oamt_nxt  = v_r;
          ocode_nxt = 56'd0;
          olen_nxt  = 3'd0;
          ostat_nxt = ST_OK;
          state_nxt = S_IDLE;
        end else if (v_r > MUL_LIMIT) begin
          valid_nxt = 1'b1;
          oamt_nxt  = 64'd0;
          ocode_nxt = 56'd0;
          olen_nxt  = 3'd0;
          ostat_nxt = ST_OVF;
          state_nxt = S_IDLE;
        end else begin
          v_nxt  = sum;
          ex_nxt = ex_r - 4'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    v_r     <= v_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    amt_r   <= amt_nxt;
    z_r     <= z_nxt;
    ex_r    <= ex_nxt;
    step_r  <= step_nxt;
    oamt_r  <= oamt_nxt;
    ocode_r <= ocode_nxt;
    olen_r  <= olen_nxt;
    ostat_r <= ostat_nxt;
  end

  assign busy           = state_r != S_IDLE;
  assign out_valid      = valid_r;
  assign out_amount_out = oamt_r;
  assign out_coded_out  = ocode_r;
  assign out_coded_len  = olen_r;
  assign out_status     = ostat_r;

`include "decimal_float_amount_codec_defines.svh"

  `DFAC_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `DFAC_ASSERT_NXT(a_start_moves, start && !busy, busy || out_valid, "request dropped")
  `DFAC_ASSERT_IMP(a_err_zero, out_valid && out_status != ST_OK, out_amount_out == 64'd0 && out_coded_len == 3'd0, "error result not cleared")
  `DFAC_ASSERT_IMP(a_zero_bound, state_r == S_TEST, z_r <= MAX_ZEROS, "too many zeros stripped")

endmodule
